FILE: design/bpq_pkg.sv
// shared constants, codes and controller/datapath types for the bucket priority queue
package bpq_pkg;

  // default sizing
  localparam int NUM_BUCKETS_DEF  = 64;
  localparam int BUCKET_DEPTH_DEF = 16;
  localparam int ENTRY_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KEY_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_fetch;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: design/bpq_if.sv
// request, response and configuration channels of the bucket priority queue
interface bpq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  priority_key;
  logic [31:0] entry_data;
  logic        is_preferred;
  modport source (output valid, operation, priority_key, entry_data, is_preferred,
                  input ready);
  modport sink   (input valid, operation, priority_key, entry_data, is_preferred,
                  output ready);
endinterface

interface bpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] removed_entry;
  logic        queue_empty;
  logic [10:0] entry_count;
  modport source (output valid, status, removed_entry, queue_empty, entry_count,
                  input ready);
  modport sink   (input valid, status, removed_entry, queue_empty, entry_count,
                  output ready);
endinterface

interface bpq_cfg_if;
  logic valid;
  logic ready;
  logic preferred_only_mode;
  modport source (output valid, preferred_only_mode, input ready);
  modport sink   (input valid, preferred_only_mode, output ready);
endinterface

FILE: design/bpq_ram.sv
// generic single write port, single read port ram with registered read
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bpq_ctrl.sv
// sequencer for one request at a time: look up bucket state, fetch entry when needed, commit
module bpq_ctrl
  import bpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  ctrl_status_t stat,
  output ctrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.need_fetch) begin
          cmd.fetch  = 1'b1;
          state_next = S_FETCH;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/bpq_dpath.sv
// bucket state, entry store, non-empty bits, counters and result register
module bpq_dpath
  import bpq_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
  parameter int ENTRY_WIDTH  = ENTRY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output ctrl_status_t        stat,
  input  logic [OP_W-1:0]     operation,
  input  logic [KEY_W-1:0]    priority_key,
  input  logic [DATA_W-1:0]   entry_data,
  input  logic                is_preferred,
  input  logic                cfg_write,
  input  logic                cfg_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_removed,
  output logic                out_empty,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int HW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int SW    = FW + 1;
  localparam int MW    = HW + FW;
  localparam int SDEP  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = $clog2(SDEP);
  localparam int CW    = $clog2(SDEP + 1);

  // latched request and control state
  logic [OP_W-1:0]        op_q;
  logic [KEY_W-1:0]       key_q;
  logic [DATA_W-1:0]      data_q;
  logic                   pref_q;
  logic [BW-1:0]          bucket_q;
  logic                   mode;
  logic [NUM_BUCKETS-1:0] nonempty;
  logic [CW-1:0]          total;
  logic [CW-1:0]          total_next;
  logic                   store_fetched;

  // ram ports
  logic [MW-1:0]          meta_rdata;
  logic [MW-1:0]          meta_wdata;
  logic                   meta_we;
  logic [BW-1:0]          lookup_bucket;
  logic [ENTRY_WIDTH-1:0] store_rdata;
  logic                   store_we;
  logic [AW-1:0]          store_waddr;
  logic [AW-1:0]          store_raddr;

  // decode
  logic [BW-1:0]          lowest;
  logic                   any_held;
  logic [HW-1:0]          eff_head;
  logic [FW-1:0]          eff_fill;
  logic [HW-1:0]          head_inc;
  logic [SW-1:0]          slot_sum;
  logic [HW-1:0]          slot;
  logic [AW-1:0]          base;
  logic [STATUS_W-1:0]    res_status;
  logic                   ins_ok;
  logic                   rem_ok;

  // lowest non-empty bucket
  always_comb begin
    lowest = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        lowest = BW'(i);
      end
    end
  end

  assign any_held      = |nonempty;
  assign lookup_bucket = (operation == OP_INSERT) ? BW'(priority_key) : lowest;

  // an empty bucket reads as head zero, fill zero
  assign eff_head = nonempty[bucket_q] ? meta_rdata[MW-1:FW] : '0;
  assign eff_fill = nonempty[bucket_q] ? meta_rdata[FW-1:0]  : '0;

  // ring arithmetic
  assign head_inc = (32'(eff_head) == BUCKET_DEPTH - 1) ? '0 : HW'(eff_head + 1'b1);
  assign slot_sum = SW'(eff_head) + SW'(eff_fill);
  assign slot     = (32'(slot_sum) >= BUCKET_DEPTH) ? HW'(slot_sum - SW'(BUCKET_DEPTH))
                                                    : HW'(slot_sum);
  assign base     = AW'(bucket_q) * AW'(BUCKET_DEPTH);

  // request outcome
  always_comb begin
    res_status = ST_OK;
    case (op_q)
      OP_INSERT: begin
        if (mode && !pref_q) begin
          res_status = ST_SKIPPED;
        end else if (32'(key_q) >= NUM_BUCKETS) begin
          res_status = ST_KEY_RANGE;
        end else if (32'(eff_fill) >= BUCKET_DEPTH) begin
          res_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (!any_held) begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign ins_ok = (op_q == OP_INSERT) && (res_status == ST_OK);
  assign rem_ok = (op_q == OP_REMOVE) && (res_status == ST_OK);

  assign stat.need_fetch = rem_ok && !store_fetched;
  assign stat.out_free   = !out_valid || out_ready;

  // remembers that the entry read was issued for this request
  always_ff @(posedge clk) begin
    if (rst) begin
      store_fetched <= 1'b0;
    end else if (cmd.fetch) begin
      store_fetched <= 1'b1;
    end else if (cmd.commit) begin
      store_fetched <= 1'b0;
    end
  end

  // ram write side and entry read address
  assign store_we    = cmd.commit && ins_ok;
  assign store_waddr = base + AW'(slot);
  assign store_raddr = base + AW'(eff_head);
  assign meta_we     = cmd.commit && (ins_ok || rem_ok);
  assign meta_wdata  = ins_ok ? {eff_head, FW'(eff_fill + 1'b1)}
                              : {head_inc, FW'(eff_fill - 1'b1)};

  always_comb begin
    total_next = total;
    if (op_q == OP_CLEAR) begin
      total_next = '0;
    end else if (ins_ok) begin
      total_next = CW'(total + 1'b1);
    end else if (rem_ok) begin
      total_next = CW'(total - 1'b1);
    end
  end

  bpq_ram #(.WIDTH(MW), .DEPTH(NUM_BUCKETS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (bucket_q),
    .wdata (meta_wdata),
    .re    (cmd.accept),
    .raddr (lookup_bucket),
    .rdata (meta_rdata)
  );

  bpq_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(SDEP)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (ENTRY_WIDTH'(data_q)),
    .re    (cmd.fetch),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= operation;
      key_q    <= priority_key;
      data_q   <= entry_data;
      pref_q   <= is_preferred;
      bucket_q <= lookup_bucket;
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= cfg_mode;
    end
  end

  // occupancy state
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
      total    <= '0;
    end else if (cmd.commit) begin
      total <= total_next;
      if (op_q == OP_CLEAR) begin
        nonempty <= '0;
      end else if (ins_ok) begin
        nonempty[bucket_q] <= 1'b1;
      end else if (rem_ok && (32'(eff_fill) == 1)) begin
        nonempty[bucket_q] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status  <= res_status;
      out_removed <= rem_ok ? DATA_W'(store_rdata) : '0;
      out_empty   <= (total_next == '0);
      out_count   <= COUNT_W'(total_next);
    end
  end

  // count and non-empty bits agree
  assert property (@(posedge clk) disable iff (rst)
    (total == '0) == (nonempty == '0))
    else $error("entry count and non-empty bits disagree");

  // a stored insert adds exactly one entry
  assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && ins_ok) |=> (total == CW'($past(total) + 1'b1)))
    else $error("insert did not add one entry");

  // a commit never overwrites an untaken result
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  // the entry read always precedes the commit of a remove
  assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && rem_ok) |-> store_fetched)
    else $error("remove committed without entry read");

endmodule

FILE: design/bucket_priority_queue_unit.sv
// Bucket priority queue with FIFO order inside each key. One request is worked
// at a time: an insert, clear or rejected request goes from accept (with the
// bucket-state ram read) to decide and commit; a successful remove adds the
// entry ram read between them, after the lowest non-empty bucket has been picked
// by a priority encoder over the per-bucket non-empty bits. A new request can be
// accepted in the cycle after the commit, while the result may still wait in the
// output register. Clear and reset act through the non-empty bits; no clearing
// pass is run.
module bucket_priority_queue_unit
  import bpq_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
  parameter int ENTRY_WIDTH  = ENTRY_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  bpq_req_if.sink    req_ch,
  bpq_rsp_if.source  rsp_ch,
  bpq_cfg_if.sink    cfg_ch
);

  ctrl_cmd_t    cmd;
  ctrl_status_t stat;

  assign cfg_ch.ready = 1'b1;

  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpq_dpath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .ENTRY_WIDTH  (ENTRY_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (req_ch.operation),
    .priority_key (req_ch.priority_key),
    .entry_data   (req_ch.entry_data),
    .is_preferred (req_ch.is_preferred),
    .cfg_write    (cfg_ch.valid),
    .cfg_mode     (cfg_ch.preferred_only_mode),
    .out_valid    (rsp_ch.valid),
    .out_ready    (rsp_ch.ready),
    .out_status   (rsp_ch.status),
    .out_removed  (rsp_ch.removed_entry),
    .out_empty    (rsp_ch.queue_empty),
    .out_count    (rsp_ch.entry_count)
  );

endmodule
